>>> design/isdf_pkg.sv
// Shared types, constants and register codes of the IPv4 descending sort and filter unit.
package isdf_pkg;

	localparam int MAX_ADDRESSES_DEF = 16;
	localparam int ADDR_BITS         = 32;
	localparam int PADDR_W           = 4;

	localparam logic [7:0] SINGLE_FIRST_RST = 8'd1;
	localparam logic [7:0] PAIR_FIRST_RST   = 8'd46;
	localparam logic [7:0] PAIR_SECOND_RST  = 8'd70;
	localparam logic [7:0] ANY_OCTET_RST    = 8'd46;

	localparam logic [1:0] REG_SINGLE_FIRST = 2'd0;
	localparam logic [1:0] REG_PAIR_FIRST   = 2'd1;
	localparam logic [1:0] REG_PAIR_SECOND  = 2'd2;
	localparam logic [1:0] REG_ANY_OCTET    = 2'd3;

	localparam logic [1:0] PASS_ALL    = 2'd0;
	localparam logic [1:0] PASS_FIRST  = 2'd1;
	localparam logic [1:0] PASS_PAIR   = 2'd2;
	localparam logic [1:0] PASS_ANY    = 2'd3;

	typedef struct packed {
		logic [ADDR_BITS-1:0] address;
		logic                 end_of_set;
	} in_item_t;

	typedef struct packed {
		logic [ADDR_BITS-1:0] sorted_address;
		logic [1:0]           filter_pass;
		logic                 last_of_run;
	} out_item_t;

	typedef struct packed {
		logic [7:0] single_first_octet;
		logic [7:0] pair_first_octet;
		logic [7:0] pair_second_octet;
		logic [7:0] any_octet_value;
	} filter_cfg_t;

	// One store read in flight during emission.
	typedef struct packed {
		logic       valid;
		logic [1:0] pass;
		logic       fin;
	} scan_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_INS_RD,
		ST_INS_CMP,
		ST_INS_PUT,
		ST_EMIT,
		ST_DRAIN,
		ST_FLUSH
	} state_t;

endpackage

>>> design/isdf_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module isdf_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

>>> design/isdf_seq.sv
// Sequencer: sorted insertion into the address store and the four-pass read scan.
module isdf_seq import isdf_pkg::*; #(
	parameter int MAX_ADDRESSES = MAX_ADDRESSES_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  in_item_t                         item,
	output logic                             busy,
	output logic                             wr_en,
	output logic [$clog2(MAX_ADDRESSES)-1:0] wr_addr,
	output logic [ADDR_BITS-1:0]             wr_data,
	output logic [$clog2(MAX_ADDRESSES)-1:0] rd_addr,
	input  logic [ADDR_BITS-1:0]             rd_data,
	output scan_t                            scan_s1
);

	localparam int IDX_W = $clog2(MAX_ADDRESSES);
	localparam int CNT_W = $clog2(MAX_ADDRESSES + 1);

	state_t               state_q, state_d;
	logic [IDX_W-1:0]     idx_q, idx_d;
	logic [1:0]           pass_q, pass_d;
	logic [CNT_W-1:0]     count_q, count_d;
	logic [ADDR_BITS-1:0] addr_q, addr_d;
	logic                 end_q, end_d;
	scan_t                scan_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q   <= '0;
			pass_q  <= '0;
			count_q <= '0;
			scan_s1 <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
			pass_q  <= pass_d;
			count_q <= count_d;
			scan_s1 <= scan_d;
		end
	end

	always_ff @(posedge clk) begin
		addr_q <= addr_d;
		end_q  <= end_d;
	end

	assign busy    = (state_q != ST_IDLE);
	// While comparing, the next lower entry is fetched so one entry moves per cycle.
	assign rd_addr = (state_q == ST_INS_CMP) ? idx_q - IDX_W'(1) : idx_q;

	always_comb begin
		logic finish;
		logic last_idx;
		state_d  = state_q;
		idx_d    = idx_q;
		pass_d   = pass_q;
		count_d  = count_q;
		addr_d   = addr_q;
		end_d    = end_q;
		scan_d   = '0;
		wr_en    = 1'b0;
		wr_addr  = idx_q + IDX_W'(1);
		wr_data  = addr_q;
		finish   = 1'b0;
		last_idx = (CNT_W'(idx_q) == count_q - CNT_W'(1));

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					addr_d = item.address;
					end_d  = item.end_of_set;
					idx_d  = '0;
					pass_d = PASS_ALL;
					if (count_q == CNT_W'(MAX_ADDRESSES)) begin
						// Store full: the address is dropped.
						state_d = item.end_of_set ? ST_EMIT : ST_IDLE;
					end else if (count_q == '0) begin
						state_d = ST_INS_PUT;
					end else begin
						idx_d   = IDX_W'(count_q - CNT_W'(1));
						state_d = ST_INS_RD;
					end
				end
			end
			ST_INS_RD: begin
				state_d = ST_INS_CMP;
			end
			ST_INS_CMP: begin
				wr_en = 1'b1;
				if (rd_data < addr_q) begin
					wr_data = rd_data;
					if (idx_q == '0) begin
						state_d = ST_INS_PUT;
					end else begin
						idx_d = idx_q - IDX_W'(1);
					end
				end else begin
					wr_data = addr_q;
					finish  = 1'b1;
				end
			end
			ST_INS_PUT: begin
				wr_en   = 1'b1;
				wr_addr = idx_q;
				wr_data = addr_q;
				finish  = 1'b1;
			end
			ST_EMIT: begin
				scan_d.valid = 1'b1;
				scan_d.pass  = pass_q;
				scan_d.fin   = (pass_q == PASS_ANY) && last_idx;
				if (last_idx) begin
					idx_d = '0;
					if (pass_q == PASS_ANY) begin
						state_d = ST_DRAIN;
					end else begin
						pass_d = pass_q + 2'd1;
					end
				end else begin
					idx_d = idx_q + IDX_W'(1);
				end
			end
			ST_DRAIN: begin
				state_d = ST_FLUSH;
			end
			ST_FLUSH: begin
				count_d = '0;
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase

		if (finish) begin
			count_d = count_q + CNT_W'(1);
			idx_d   = '0;
			pass_d  = PASS_ALL;
			state_d = end_q ? ST_EMIT : ST_IDLE;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(MAX_ADDRESSES))
		else $error("stored count exceeds capacity");

	a_no_write_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT || state_q == ST_DRAIN || state_q == ST_FLUSH) |-> !wr_en)
		else $error("store written during emission");

	a_fin_to_flush: assert property (@(posedge clk) disable iff (!arst_n)
		(scan_s1.valid && scan_s1.fin) |=> (state_q == ST_FLUSH))
		else $error("final scan read not followed by flush");

endmodule

>>> design/isdf_emit.sv
// Result stage: pass filters and a one-deep hold that marks the final result of a run.
module isdf_emit import isdf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  filter_cfg_t          cfg,
	input  scan_t                scan_s1,
	input  logic [ADDR_BITS-1:0] rd_data,
	output logic                 result_valid,
	output out_item_t            result
);

	logic                 match;
	logic                 fin_s2;
	logic                 held_valid_q;
	logic [ADDR_BITS-1:0] held_addr_q;
	logic [1:0]           held_pass_q;
	logic                 emit_now;
	logic                 take;

	always_comb begin
		case (scan_s1.pass)
			PASS_ALL:   match = 1'b1;
			PASS_FIRST: match = (rd_data[31:24] == cfg.single_first_octet);
			PASS_PAIR:  match = (rd_data[31:24] == cfg.pair_first_octet) &&
			                    (rd_data[23:16] == cfg.pair_second_octet);
			PASS_ANY:   match = (rd_data[31:24] == cfg.any_octet_value) ||
			                    (rd_data[23:16] == cfg.any_octet_value) ||
			                    (rd_data[15:8]  == cfg.any_octet_value) ||
			                    (rd_data[7:0]   == cfg.any_octet_value);
			default:    match = 1'b0;
		endcase
	end

	// A match is held back one step; it goes out when the next match arrives,
	// or as the final result once the scan has ended.
	assign take     = scan_s1.valid && match;
	assign emit_now = (take && held_valid_q) || fin_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fin_s2       <= 1'b0;
			held_valid_q <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			fin_s2       <= scan_s1.valid && scan_s1.fin;
			result_valid <= emit_now;
			if (take) begin
				held_valid_q <= 1'b1;
			end else if (fin_s2) begin
				held_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			held_addr_q <= rd_data;
			held_pass_q <= scan_s1.pass;
		end
		if (emit_now) begin
			result.sorted_address <= held_addr_q;
			result.filter_pass    <= held_pass_q;
			result.last_of_run    <= fin_s2;
		end
	end

	a_held_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		fin_s2 |-> held_valid_q)
		else $error("run ended with no result held");

	a_last_is_alone: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.last_of_run) |=> !result_valid)
		else $error("transfer after the final result of a run");

endmodule

>>> design/ipv4_descending_sort_filter_unit.sv
// Top level of the IPv4 descending sort and filter unit with its configuration registers.
//
// Usage: an address is taken on item at a clock edge where start is high and busy
// is low. Each address is inserted into a store kept in descending order; the item
// with end_of_set high closes the set. The block then emits the set in four passes
// (all, first octet, first two octets, any octet), each descending, one transfer per
// result_valid cycle, and last_of_run marks the final transfer of the run. The
// receiver cannot stall: result_valid is high for a single cycle per result.
// Sequence: an insertion reads the last stored entry, moves each smaller entry up by
// one in a compare-and-move loop over the single store port and writes the address
// into the gap, or writes it directly into an empty store; a full store drops it.
// Closing a set then holds busy while each of the four passes reads the store, one
// store read per cycle, then a drain and a flush state follow; the final result is
// on result in the first cycle with busy low. Reset clears the stored count, loads
// the filter registers with 1, 46, 70, 46 and does not clear the store. The user must
// write registers over the APB port only while idle; the block does not enforce it.
module ipv4_descending_sort_filter_unit import isdf_pkg::*; #(
	parameter int MAX_ADDRESSES = MAX_ADDRESSES_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  in_item_t           item,
	output logic               busy,
	output logic               result_valid,
	output out_item_t          result,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int IDX_W = $clog2(MAX_ADDRESSES);

	filter_cfg_t          cfg_q;
	logic                 wr_en;
	logic [IDX_W-1:0]     wr_addr;
	logic [ADDR_BITS-1:0] wr_data;
	logic [IDX_W-1:0]     rd_addr;
	logic [ADDR_BITS-1:0] rd_data;
	scan_t                scan_s1;
	logic                 cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.single_first_octet <= SINGLE_FIRST_RST;
			cfg_q.pair_first_octet   <= PAIR_FIRST_RST;
			cfg_q.pair_second_octet  <= PAIR_SECOND_RST;
			cfg_q.any_octet_value    <= ANY_OCTET_RST;
		end else if (cfg_write) begin
			case (paddr[3:2])
				REG_SINGLE_FIRST: cfg_q.single_first_octet <= pwdata[7:0];
				REG_PAIR_FIRST:   cfg_q.pair_first_octet   <= pwdata[7:0];
				REG_PAIR_SECOND:  cfg_q.pair_second_octet  <= pwdata[7:0];
				REG_ANY_OCTET:    cfg_q.any_octet_value    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_SINGLE_FIRST: prdata = {24'd0, cfg_q.single_first_octet};
			REG_PAIR_FIRST:   prdata = {24'd0, cfg_q.pair_first_octet};
			REG_PAIR_SECOND:  prdata = {24'd0, cfg_q.pair_second_octet};
			REG_ANY_OCTET:    prdata = {24'd0, cfg_q.any_octet_value};
			default:          prdata = '0;
		endcase
	end

	isdf_ram #(
		.WIDTH (ADDR_BITS),
		.DEPTH (MAX_ADDRESSES)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	isdf_seq #(
		.MAX_ADDRESSES (MAX_ADDRESSES)
	) u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (start),
		.item    (item),
		.busy    (busy),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_addr (rd_addr),
		.rd_data (rd_data),
		.scan_s1 (scan_s1)
	);

	isdf_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg_q),
		.scan_s1      (scan_s1),
		.rd_data      (rd_data),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

>>> sim/tb_ipv4_descending_sort_filter_unit.sv
// Self-checking testbench for the IPv4 descending sort and filter unit.
module tb_ipv4_descending_sort_filter_unit import isdf_pkg::*; ();

	localparam int CYCLE_LIMIT  = 300000;
	localparam int QUIET_CYCLES = 24;
	localparam int SET_QUOTA    = 62;

	localparam logic [1:0] PASS_ORDER [4] = '{PASS_ALL, PASS_FIRST, PASS_PAIR, PASS_ANY};
	localparam logic [1:0] REG_ORDER  [4] = '{REG_SINGLE_FIRST, REG_PAIR_FIRST,
		REG_PAIR_SECOND, REG_ANY_OCTET};

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	in_item_t           item = '0;
	logic               busy;
	logic               result_valid;
	out_item_t          result;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	ipv4_descending_sort_filter_unit uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.item(item),
		.busy(busy),
		.result_valid(result_valid),
		.result(result),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Shadow copy of the sorted store and the filter registers.
	logic [31:0] sorted_shadow [MAX_ADDRESSES_DEF];
	int          shadow_count = 0;
	logic [7:0]  cfg_single, cfg_pair_first, cfg_pair_second, cfg_any;

	in_item_t    addr_feed [$];
	out_item_t   pending_emits [$];

	bit          presenting = 1'b0;
	bit          took_item = 1'b0;
	int          gap_left = 0;
	int          gap_max = 8;
	logic [31:0] prev_addr = '0;

	int          errors = 0;
	int          cycle_count = 0;
	int          addrs_taken = 0;
	int          addrs_dropped = 0;
	int          sets_closed = 0;
	int          results_seen = 0;
	int          reg_settings = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic bit pass_hit(logic [1:0] pass_code, logic [31:0] a);
		case (pass_code)
			PASS_ALL:   return 1'b1;
			PASS_FIRST: return a[31:24] == cfg_single;
			PASS_PAIR:  return a[31:24] == cfg_pair_first && a[23:16] == cfg_pair_second;
			default:    return a[31:24] == cfg_any || a[23:16] == cfg_any ||
				a[15:8] == cfg_any || a[7:0] == cfg_any;
		endcase
	endfunction

	function automatic logic [7:0] cfg_value(logic [1:0] idx);
		case (idx)
			REG_SINGLE_FIRST: return cfg_single;
			REG_PAIR_FIRST:   return cfg_pair_first;
			REG_PAIR_SECOND:  return cfg_pair_second;
			default:          return cfg_any;
		endcase
	endfunction

	// Inserts one address in descending order and, on the closing item, queues the
	// four filtered passes that the block must emit.
	task automatic sort_insert_and_emit(in_item_t it);
		int pos;
		int i;
		int p;
		out_item_t r;
		addrs_taken++;
		if (shadow_count < MAX_ADDRESSES_DEF) begin
			pos = 0;
			while (pos < shadow_count && sorted_shadow[pos] >= it.address)
				pos++;
			for (i = shadow_count; i > pos; i--)
				sorted_shadow[i] = sorted_shadow[i-1];
			sorted_shadow[pos] = it.address;
			shadow_count++;
		end else begin
			addrs_dropped++;
		end
		if (it.end_of_set) begin
			for (p = 0; p < 4; p++) begin
				for (i = 0; i < shadow_count; i++) begin
					if (pass_hit(PASS_ORDER[p], sorted_shadow[i])) begin
						r.sorted_address = sorted_shadow[i];
						r.filter_pass    = PASS_ORDER[p];
						r.last_of_run    = 1'b0;
						pending_emits = {pending_emits, r};
					end
				end
			end
			// The closing item always leaves at least one address stored.
			pending_emits[pending_emits.size()-1].last_of_run = 1'b1;
			shadow_count = 0;
			sets_closed++;
		end
	endtask

	task automatic check_result(out_item_t got);
		out_item_t want;
		results_seen++;
		if (pending_emits.size() == 0) begin
			$error("unexpected result: sorted_address %h filter_pass %0d last_of_run %0b",
				got.sorted_address, got.filter_pass, got.last_of_run);
			errors++;
		end else begin
			want = pending_emits.pop_front();
			if (got.sorted_address !== want.sorted_address) begin
				$error("sorted_address: expected %h, got %h",
					want.sorted_address, got.sorted_address);
				errors++;
			end
			if (got.filter_pass !== want.filter_pass) begin
				$error("filter_pass: expected %0d, got %0d", want.filter_pass, got.filter_pass);
				errors++;
			end
			if (got.last_of_run !== want.last_of_run) begin
				$error("last_of_run: expected %0b, got %0b", want.last_of_run, got.last_of_run);
				errors++;
			end
		end
	endtask

	// Sender: presents queued items and idles a random number of cycles after each transfer.
	always @(negedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
			presenting = 1'b0;
			gap_left = 0;
		end else begin
			if (presenting && took_item) begin
				presenting = 1'b0;
				gap_left = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			end
			if (!presenting) begin
				if (gap_left > 0) begin
					gap_left--;
					start <= 1'b0;
				end else if (addr_feed.size() != 0) begin
					item <= addr_feed.pop_front();
					start <= 1'b1;
					presenting = 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor: checks each result, then predicts from each accepted item.
	always @(posedge clk) begin
		if (!arst_n) begin
			took_item <= 1'b0;
		end else begin
			took_item <= start && !busy;
			if (result_valid)
				check_result(result);
			if (start && !busy)
				sort_insert_and_emit(item);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("TEST FAILED");
			$finish;
		end
	end

	function automatic void push_addr(logic [31:0] a, logic last);
		in_item_t it;
		it.address    = a;
		it.end_of_set = last;
		addr_feed = {addr_feed, it};
	endfunction

	// Random address, with octets often taken from the filter registers so that
	// every pass finds matches, and with some duplicates and extremes.
	function automatic logic [31:0] pick_address();
		logic [31:0] a;
		int k;
		a = $urandom();
		for (k = 0; k < 4; k++) begin
			case ($urandom_range(0, 11))
				0: a[8*k +: 8] = cfg_single;
				1: a[8*k +: 8] = cfg_pair_first;
				2: a[8*k +: 8] = cfg_pair_second;
				3: a[8*k +: 8] = cfg_any;
				default: ;
			endcase
		end
		case ($urandom_range(0, 15))
			0, 1, 2: a[31:16] = {cfg_pair_first, cfg_pair_second};
			3, 4:    a[31:24] = cfg_single;
			5, 6:    a = prev_addr;
			7:       a = ($urandom_range(0, 1) != 0) ? 32'hFFFF_FFFF : 32'h0000_0000;
			default: ;
		endcase
		prev_addr = a;
		return a;
	endfunction

	function automatic int queue_set(int n);
		int i;
		for (i = 0; i < n; i++)
			push_addr(pick_address(), i == n - 1);
		return n;
	endfunction

	task automatic write_filter_reg(logic [1:0] idx, logic [7:0] val);
		logic [31:0] word;
		word = $urandom();
		word[7:0] = val;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= word;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		case (idx)
			REG_SINGLE_FIRST: cfg_single = val;
			REG_PAIR_FIRST:   cfg_pair_first = val;
			REG_PAIR_SECOND:  cfg_pair_second = val;
			default:          cfg_any = val;
		endcase
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	task automatic read_filter_reg(logic [1:0] idx);
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		paddr   <= {idx, 2'b00};
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata[7:0] !== cfg_value(idx)) begin
			$error("prdata of register %0d: expected %h, got %h", idx, cfg_value(idx),
				prdata[7:0]);
			errors++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// Holds off until every queued item is transferred, every result is in and the
	// block has gone idle, then lets it settle.
	task automatic wait_quiet();
		@(negedge clk);
		while (addr_feed.size() != 0 || presenting || pending_emits.size() != 0 || busy)
			@(negedge clk);
		repeat (QUIET_CYCLES) @(negedge clk);
	endtask

	initial begin
		int phase;
		int queued;
		int r;
		int n;
		logic [7:0] vals [4];
		cfg_single      = SINGLE_FIRST_RST;
		cfg_pair_first  = PAIR_FIRST_RST;
		cfg_pair_second = PAIR_SECOND_RST;
		cfg_any         = ANY_OCTET_RST;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		for (r = 0; r < 4; r++)
			read_filter_reg(REG_ORDER[r]);

		// Directed sets under the reset filters: extremes, duplicates and a hit in
		// every pass; a single-address set whose only result is in the first pass;
		// a full store whose closing address is dropped.
		push_addr(32'hFFFF_FFFF, 1'b0);
		push_addr(32'h0000_0000, 1'b0);
		push_addr(32'h2E46_0A0B, 1'b0);
		push_addr(32'h2E46_0A0B, 1'b0);
		push_addr(32'h0102_032E, 1'b1);
		push_addr(32'h1234_5678, 1'b1);
		for (r = 0; r < MAX_ADDRESSES_DEF; r++)
			push_addr(pick_address(), 1'b0);
		push_addr(32'h8000_0001, 1'b1);
		wait_quiet();

		for (phase = 1; phase <= 6; phase++) begin
			for (r = 0; r < 4; r++) begin
				if (phase == 1)
					vals[r] = 8'h00;
				else if (phase == 2)
					vals[r] = 8'hFF;
				else
					vals[r] = 8'($urandom_range(0, 255));
			end
			for (r = 0; r < 4; r++)
				write_filter_reg(REG_ORDER[r], vals[r]);
			for (r = 0; r < 4; r++)
				read_filter_reg(REG_ORDER[r]);
			reg_settings++;
			// Odd phases run back to back with no idle cycles on the sender.
			gap_max = (phase % 2 != 0) ? 0 : 8;
			queued = 0;
			while (queued < SET_QUOTA) begin
				if ($urandom_range(0, 7) == 0)
					n = $urandom_range(MAX_ADDRESSES_DEF + 1, MAX_ADDRESSES_DEF + 4);
				else
					n = $urandom_range(1, MAX_ADDRESSES_DEF);
				queued += queue_set(n);
			end
			wait_quiet();
		end

		if (pending_emits.size() != 0) begin
			$error("%0d expected results never arrived", pending_emits.size());
			errors++;
		end
		$display("Sent %0d addresses in %0d sets (%0d dropped at capacity), checked %0d results",
			addrs_taken, sets_closed, addrs_dropped, results_seen);
		$display("Filter registers reprogrammed %0d times, including all-zero and all-one",
			reg_settings);
		if (errors == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
